@@ src/chain_code_area_winding_macros.svh @@
// Assertion macros used by the chain-code area and winding number block.
`ifndef CHAIN_CODE_AREA_WINDING_MACROS_SVH
`define CHAIN_CODE_AREA_WINDING_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CCAW_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define CCAW_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ccaw_pkg.sv @@
// Types, constants and helpers of the chain-code area and winding number block.
package ccaw_pkg;

  localparam int COORD_BITS = 16;
  localparam int CFG_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int AREA_W     = 32;
  localparam int WIND_W     = 16;
  localparam int STEP_CNT_W = 15;
  localparam int DIFF_W     = ((COORD_BITS > CFG_W) ? COORD_BITS : CFG_W) + 1;

  localparam logic [STEP_CNT_W-1:0] STEP_CNT_MAX = {STEP_CNT_W{1'b1}};

  typedef enum logic [1:0] {
    DIR_POS_X = 2'd0,
    DIR_POS_Y = 2'd1,
    DIR_NEG_X = 2'd2,
    DIR_NEG_Y = 2'd3
  } dir_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_QUERY_X = 2'd2,
    CFG_QUERY_Y = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] step_direction;
    logic       last_step;
  } in_word_t;

  typedef struct packed {
    logic signed [AREA_W-1:0] signed_area;
    logic signed [WIND_W-1:0] winding_number;
    logic                     on_outline;
    logic [STEP_CNT_W-1:0]    step_count;
  } out_word_t;

  typedef struct packed {
    logic signed [CFG_W-1:0] start_x;
    logic signed [CFG_W-1:0] start_y;
    logic signed [CFG_W-1:0] query_x;
    logic signed [CFG_W-1:0] query_y;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pos_x;
    logic signed [COORD_BITS-1:0] pos_y;
    logic        [AREA_W-1:0]     area_sum;
    logic        [WIND_W-1:0]     crossing_count;
    logic                         touch_flag;
    logic        [STEP_CNT_W-1:0] steps_seen;
  } trace_state_t;

  // Sign-extends a start register and wraps it into the coordinate width.
  function automatic logic signed [COORD_BITS-1:0] to_coord(input logic signed [CFG_W-1:0] v);
    logic signed [2*COORD_BITS+CFG_W-1:0] wide;
    wide = (2*COORD_BITS+CFG_W)'(v);
    return wide[COORD_BITS-1:0];
  endfunction

endpackage

@@ src/chain_code_area_winding.sv @@
// Top level of the chain-code outline area and winding number block.
//
// Steps of a closed four-direction chain-code outline arrive on the input
// channel, one word per step, each carrying a direction and a last-step mark.
// The block tracks the current position, sums the signed area and counts
// crossings of the ray to the right of the query point. The final step of an
// outline produces one result word on the output channel (area, winding
// number, on-outline flag and step count); other steps produce none.
// The four configuration registers (start point and query point) are written
// through the configuration channel, which is always ready. The user must
// write them only while idle; the block itself does not enforce this.
// A final step is held in the input register, then its result is written into
// the result register. Throughput is one step per cycle while no final step
// waits; the input register feeds a single combinational update into the
// state and result registers.
// When the receiver stalls, the result register holds its word; further
// ordinary steps keep flowing, and only a following final step waits in the
// input register until the result has been taken.
// Reset clears the configuration to zero, empties both registers and restarts
// the outline accumulators.
`include "chain_code_area_winding_macros.svh"

module chain_code_area_winding (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ccaw_pkg::in_word_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ccaw_pkg::out_word_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ccaw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ccaw_pkg::CFG_W-1:0]     cfg_data_i
);
  import ccaw_pkg::*;

  cfg_t         cfg_q;
  trace_state_t state_q, state_d;
  in_word_t     in_word_q;
  logic         in_valid_q;
  out_word_t    out_word_q, result;
  logic         out_valid_q;
  logic         out_free, step_fire;

  // Configuration words are always taken; they must only be sent while idle (not enforced).
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_START_X: cfg_q.start_x <= cfg_data_i;
        CFG_START_Y: cfg_q.start_y <= cfg_data_i;
        CFG_QUERY_X: cfg_q.query_x <= cfg_data_i;
        CFG_QUERY_Y: cfg_q.query_y <= cfg_data_i;
        default:     cfg_q         <= cfg_q;
      endcase
    end
  end

  // The result register is free when empty or when its word leaves this cycle.
  assign out_free = !out_valid_q || out_ready_i;

  // A registered step is processed unless it is a final step facing a full
  // result register.
  assign step_fire  = in_valid_q && (!in_word_q.last_step || out_free);
  assign in_ready_o = !in_valid_q || step_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (step_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_word_q <= in_data_i;
    end
  end

  ccaw_update u_update (
    .state_i  (state_q),
    .word_i   (in_word_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (step_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_fire && in_word_q.last_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && in_word_q.last_step) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

  // A final step never overwrites a result that has not been taken.
  `CCAW_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni,
                   step_fire && in_word_q.last_step && out_valid_q, out_ready_i,
                   "final step overwrote a pending result")

  // The accumulators restart once a final step has been processed.
  `CCAW_ASSERT_NXT(a_restart, clk_i, rst_ni, step_fire && in_word_q.last_step,
                   state_q.steps_seen == '0 && !state_q.touch_flag,
                   "accumulators did not restart after a final step")

  // A touching query point reports a zero winding number.
  `CCAW_ASSERT_IMP(a_touch_wind, clk_i, rst_ni, out_valid_o && out_data_o.on_outline,
                   out_data_o.winding_number == '0,
                   "winding number not zero on the outline")

  // Every reported outline has at least its final step.
  `CCAW_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, out_valid_o,
                   out_data_o.step_count != '0,
                   "result reported with a zero step count")

endmodule

@@ src/ccaw_update.sv @@
// Combinational per-step update of position, area, crossing count and step count.
module ccaw_update (
  input  ccaw_pkg::trace_state_t state_i,
  input  ccaw_pkg::in_word_t     word_i,
  input  ccaw_pkg::cfg_t         cfg_i,
  output ccaw_pkg::trace_state_t state_o,
  output ccaw_pkg::out_word_t    result_o
);
  import ccaw_pkg::*;

  logic signed [COORD_BITS-1:0] pos_x, pos_y;
  logic signed [DIFF_W-1:0]     vec_x, vec_y;
  logic        [AREA_W-1:0]     pos_y_ext;
  logic        [AREA_W-1:0]     area_d;
  logic        [WIND_W-1:0]     cross_d;
  logic                         touch_d;
  logic        [STEP_CNT_W-1:0] steps_d;
  logic signed [COORD_BITS-1:0] next_x, next_y;
  logic                         vec_x_pos, vec_x_zero;
  logic                         up_cross, down_cross;
  dir_e                         dir;

  assign dir = dir_e'(word_i.step_direction);

  // The first step of an outline starts from the start registers.
  assign pos_x = (state_i.steps_seen == '0) ? to_coord(cfg_i.start_x) : state_i.pos_x;
  assign pos_y = (state_i.steps_seen == '0) ? to_coord(cfg_i.start_y) : state_i.pos_y;

  assign vec_x = DIFF_W'(pos_x) - DIFF_W'(cfg_i.query_x);
  assign vec_y = DIFF_W'(pos_y) - DIFF_W'(cfg_i.query_y);

  assign vec_x_zero = (vec_x == '0);
  assign vec_x_pos  = !vec_x[DIFF_W-1] && !vec_x_zero;

  // An upward step leaving the query row, or a downward step arriving on it.
  assign up_cross   = (dir == DIR_POS_Y) && (vec_y == '0);
  assign down_cross = (dir == DIR_NEG_Y) && (vec_y == DIFF_W'(1));

  assign pos_y_ext = AREA_W'(pos_y);

  always_comb begin
    area_d = state_i.area_sum;
    next_x = pos_x;
    next_y = pos_y;
    unique case (dir)
      DIR_POS_X: begin
        area_d = state_i.area_sum + pos_y_ext;
        next_x = pos_x + COORD_BITS'(1);
      end
      DIR_POS_Y: begin
        next_y = pos_y + COORD_BITS'(1);
      end
      DIR_NEG_X: begin
        area_d = state_i.area_sum - pos_y_ext;
        next_x = pos_x - COORD_BITS'(1);
      end
      DIR_NEG_Y: begin
        next_y = pos_y - COORD_BITS'(1);
      end
      default: begin
        area_d = state_i.area_sum;
      end
    endcase
  end

  always_comb begin
    cross_d = state_i.crossing_count;
    touch_d = state_i.touch_flag;
    if (!state_i.touch_flag && (up_cross || down_cross)) begin
      if (vec_x_pos) begin
        cross_d = up_cross ? state_i.crossing_count + WIND_W'(1)
                           : state_i.crossing_count - WIND_W'(1);
      end else if (vec_x_zero) begin
        touch_d = 1'b1;
      end
    end
  end

  assign steps_d = (state_i.steps_seen == STEP_CNT_MAX) ? state_i.steps_seen
                                                          : state_i.steps_seen + STEP_CNT_W'(1);

  always_comb begin
    result_o.signed_area    = area_d;
    result_o.winding_number = touch_d ? '0 : cross_d;
    result_o.on_outline     = touch_d;
    result_o.step_count     = steps_d;
  end

  // After the final step everything restarts; the position reloads on the next step.
  always_comb begin
    state_o.pos_x = next_x;
    state_o.pos_y = next_y;
    if (word_i.last_step) begin
      state_o.area_sum       = '0;
      state_o.crossing_count = '0;
      state_o.touch_flag     = 1'b0;
      state_o.steps_seen     = '0;
    end else begin
      state_o.area_sum       = area_d;
      state_o.crossing_count = cross_d;
      state_o.touch_flag     = touch_d;
      state_o.steps_seen     = steps_d;
    end
  end

endmodule

@@ sim/chain_code_area_winding_checker.sv @@
// Outline predictor and result scoreboard for the chain-code area and winding block.
module chain_code_area_winding_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_ready_i,
  input  ccaw_pkg::in_word_t             in_data_i,
  input  logic                           out_valid_i,
  input  logic                           out_ready_i,
  input  ccaw_pkg::out_word_t            out_data_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [ccaw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ccaw_pkg::CFG_W-1:0]     cfg_data_i,
  output int                             fail_count_o,
  output int                             pending_o
);
  import ccaw_pkg::*;

  logic signed [CFG_W-1:0]      start_x_q, start_y_q, query_x_q, query_y_q;
  logic signed [COORD_BITS-1:0] pos_x_q, pos_y_q;
  logic        [AREA_W-1:0]     area_q;
  logic        [WIND_W-1:0]     crossings_q;
  logic                         touch_q;
  logic        [STEP_CNT_W-1:0] steps_q;
  out_word_t                    summary_q[$];
  int                           mismatches = 0;

  // Advances the outline by one step and queues the summary on a final step.
  task trace_step(input in_word_t w);
    logic [AREA_W-1:0] y_ext;
    int                vx, vy, dy;
    out_word_t         res;
    if (steps_q == '0) begin
      pos_x_q = to_coord(start_x_q);
      pos_y_q = to_coord(start_y_q);
    end
    y_ext = {{(AREA_W-COORD_BITS){pos_y_q[COORD_BITS-1]}}, pos_y_q};
    dy = 0;
    case (dir_e'(w.step_direction))
      DIR_POS_X: area_q = area_q + y_ext;
      DIR_NEG_X: area_q = area_q - y_ext;
      DIR_POS_Y: dy = 1;
      default:   dy = -1;
    endcase
    vx = int'(pos_x_q) - int'(query_x_q);
    vy = int'(pos_y_q) - int'(query_y_q);
    // Only vertical steps can cross the ray; a crossing through the point freezes the count.
    if (!touch_q) begin
      if (vy <= 0 && vy + dy > 0) begin
        if (vx > 0) crossings_q = crossings_q + 1'b1;
        else if (vx == 0) touch_q = 1'b1;
      end else if (vy > 0 && vy + dy <= 0) begin
        if (vx > 0) crossings_q = crossings_q - 1'b1;
        else if (vx == 0) touch_q = 1'b1;
      end
    end
    case (dir_e'(w.step_direction))
      DIR_POS_X: pos_x_q = pos_x_q + 1'b1;
      DIR_NEG_X: pos_x_q = pos_x_q - 1'b1;
      DIR_POS_Y: pos_y_q = pos_y_q + 1'b1;
      default:   pos_y_q = pos_y_q - 1'b1;
    endcase
    if (steps_q != STEP_CNT_MAX) steps_q = steps_q + 1'b1;
    if (w.last_step) begin
      res.signed_area    = area_q;
      res.winding_number = touch_q ? '0 : crossings_q;
      res.on_outline     = touch_q;
      res.step_count     = steps_q;
      summary_q.push_back(res);
      area_q      = '0;
      crossings_q = '0;
      touch_q     = 1'b0;
      steps_q     = '0;
    end
  endtask

  task check_summary(input out_word_t got);
    out_word_t exp;
    if (summary_q.size() == 0) begin
      $display("%0t: unexpected result word, expected none, got %p", $time, got);
      mismatches++;
    end else begin
      exp = summary_q.pop_front();
      if (got.signed_area !== exp.signed_area) begin
        $display("%0t: signed_area mismatch, expected %0d, got %0d", $time,
                 exp.signed_area, got.signed_area);
        mismatches++;
      end
      if (got.winding_number !== exp.winding_number) begin
        $display("%0t: winding_number mismatch, expected %0d, got %0d", $time,
                 exp.winding_number, got.winding_number);
        mismatches++;
      end
      if (got.on_outline !== exp.on_outline) begin
        $display("%0t: on_outline mismatch, expected %0d, got %0d", $time,
                 exp.on_outline, got.on_outline);
        mismatches++;
      end
      if (got.step_count !== exp.step_count) begin
        $display("%0t: step_count mismatch, expected %0d, got %0d", $time,
                 exp.step_count, got.step_count);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q   = '0;
      start_y_q   = '0;
      query_x_q   = '0;
      query_y_q   = '0;
      pos_x_q     = '0;
      pos_y_q     = '0;
      area_q      = '0;
      crossings_q = '0;
      touch_q     = 1'b0;
      steps_q     = '0;
      summary_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) check_summary(out_data_i);
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START_X: start_x_q = cfg_data_i;
          CFG_START_Y: start_y_q = cfg_data_i;
          CFG_QUERY_X: query_x_q = cfg_data_i;
          default:     query_y_q = cfg_data_i;
        endcase
      end
      if (in_valid_i && in_ready_i) trace_step(in_data_i);
    end
    fail_count_o <= mismatches;
    pending_o    <= summary_q.size();
  end

endmodule

@@ sim/chain_code_area_winding_tb.sv @@
// Testbench top of the chain-code area and winding block: stimulus, handshake pacing and verdict.
module chain_code_area_winding_tb;
  import ccaw_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 3;
  // A final step's result passes the input and result registers; allow a margin.
  localparam int DRAIN_CYCLES = 8;
  // The limit leaves room for about a thousand words, each waiting out the longest gap and stall.
  localparam int LIMIT_CYCLES = 200_000;
  localparam int RANDOM_ITEMS = 900;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  in_word_t             in_data_i   = '0;
  logic                 out_ready_i = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i  = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  out_word_t            out_data_o;
  logic                 cfg_ready_o;

  int   fail_count;
  int   pending_words;
  int   cycle_count = 0;
  int   random_items = 0;
  int   burst_left = 0;
  dir_e outline_q[$];

  chain_code_area_winding u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  chain_code_area_winding_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_words)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver pacing. Whenever the current mode runs out, a new one is drawn: always
  // ready, randomly thinned readiness, or long stalls broken by short ready windows.
  // Stalls matter because a following final step must then wait in the block.
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_stall_left = 0;

  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(50, 400);
    end
    rx_mode_left--;
    case (rx_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_stall_left == 0) rx_stall_left = $urandom_range(2, 28);
        rx_stall_left--;
        out_ready_i <= (rx_stall_left < 3);
      end
    endcase
  end

  // Offers one step word and returns at the falling edge after it was taken.
  // The sender works in bursts; a gap before a burst is sometimes zero, which
  // gives stretches of back-to-back words. Valid stays high across a burst,
  // so it is never lowered and raised within one time step.
  task automatic put_step(input dir_e dir, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= '{step_direction: dir, last_step: last};
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Sends the queued outline, marking its final step.
  task automatic send_outline();
    foreach (outline_q[i]) put_step(outline_q[i], i == outline_q.size() - 1);
    outline_q.delete();
  endtask

  // A random walk of the given length followed by the straight path back to
  // the start, so the outline closes with random content.
  task automatic queue_closed_walk(input int len);
    int   dx, dy;
    dir_e dir;
    dx = 0;
    dy = 0;
    repeat (len) begin
      dir = dir_e'($urandom_range(0, 3));
      outline_q.push_back(dir);
      case (dir)
        DIR_POS_X: dx++;
        DIR_NEG_X: dx--;
        DIR_POS_Y: dy++;
        default:   dy--;
      endcase
    end
    while (dx > 0) begin outline_q.push_back(DIR_NEG_X); dx--; end
    while (dx < 0) begin outline_q.push_back(DIR_POS_X); dx++; end
    while (dy > 0) begin outline_q.push_back(DIR_NEG_Y); dy--; end
    while (dy < 0) begin outline_q.push_back(DIR_POS_Y); dy++; end
  endtask

  // A rectangle from the start point, counter-clockwise or clockwise.
  task automatic queue_rect(input int w, input int h, input logic ccw);
    if (ccw) begin
      repeat (w) outline_q.push_back(DIR_POS_X);
      repeat (h) outline_q.push_back(DIR_POS_Y);
      repeat (w) outline_q.push_back(DIR_NEG_X);
      repeat (h) outline_q.push_back(DIR_NEG_Y);
    end else begin
      repeat (h) outline_q.push_back(DIR_POS_Y);
      repeat (w) outline_q.push_back(DIR_POS_X);
      repeat (h) outline_q.push_back(DIR_NEG_Y);
      repeat (w) outline_q.push_back(DIR_NEG_X);
    end
  endtask

  // Noise: an open outline of random steps that need not return to the start.
  task automatic queue_open_path(input int len);
    repeat (len) outline_q.push_back(dir_e'($urandom_range(0, 3)));
  endtask

  // Lets every predicted result arrive, then waits out the drain margin for the
  // pipeline to empty. Every phase ends on a final step, so nothing is left
  // half-way through an outline when the registers change.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
  endtask

  // Writes all four registers while the block is idle.
  task automatic set_points(input logic [CFG_W-1:0] sx, input logic [CFG_W-1:0] sy,
                            input logic [CFG_W-1:0] qx, input logic [CFG_W-1:0] qy);
    settle();
    write_reg(CFG_START_X, sx);
    write_reg(CFG_START_Y, sy);
    write_reg(CFG_QUERY_X, qx);
    write_reg(CFG_QUERY_Y, qy);
    cfg_valid_i <= 1'b0;
  endtask

  // Picks a start point and a query point. Most settings put the query point
  // within a few units of the start, so that walks cross the ray and touch the
  // point; some of these start at coordinate extremes, where positions wrap.
  task automatic random_points();
    logic [CFG_W-1:0] sx, sy, qx, qy;
    int               pick;
    pick = $urandom_range(0, 3);
    sx = $urandom_range(0, 16'hFFFF);
    sy = $urandom_range(0, 16'hFFFF);
    if (pick == 3) begin
      case ($urandom_range(0, 3))
        0:       sx = 16'h7FFF;
        1:       sx = 16'h8000;
        2:       sx = 16'hFFFF;
        default: sx = 16'h0000;
      endcase
      case ($urandom_range(0, 3))
        0:       sy = 16'h7FFF;
        1:       sy = 16'h8000;
        2:       sy = 16'hFFFF;
        default: sy = 16'h0000;
      endcase
    end
    if (pick == 0) begin
      qx = $urandom_range(0, 16'hFFFF);
      qy = $urandom_range(0, 16'hFFFF);
    end else begin
      qx = sx + CFG_W'($urandom_range(0, 8) - 4);
      qy = sy + CFG_W'($urandom_range(0, 8) - 4);
    end
    set_points(sx, sy, qx, qy);
  endtask

  initial begin
    int kind;
    int phase_items;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part. With the reset configuration both points sit at the
    // origin: a single-step outline, then the unit square, whose left edge
    // runs down through the query point and so sets the on-outline flag.
    outline_q.push_back(DIR_POS_Y);
    send_outline();
    queue_rect(1, 1, 1'b1);
    send_outline();

    // A clockwise square around the query point winds minus one.
    set_points(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
    queue_rect(2, 2, 1'b0);
    send_outline();

    // Start at the corner of the coordinate range: the x axis wraps.
    set_points(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    queue_rect(1, 1, 1'b1);
    send_outline();

    // A counter-clockwise square around the query point winds plus one.
    set_points(16'h0000, 16'h0000, 16'h0001, 16'h0001);
    queue_rect(2, 2, 1'b1);
    send_outline();

    // Random part: phases of fresh points, each filled with mostly closed
    // walks and rectangles, and some open paths as noise.
    while (random_items < RANDOM_ITEMS) begin
      random_points();
      phase_items = 0;
      while (phase_items < 90) begin
        kind = $urandom_range(0, 9);
        if (kind <= 5) queue_closed_walk($urandom_range(1, 24));
        else if (kind <= 7) queue_rect($urandom_range(1, 6), $urandom_range(1, 6),
                                       $urandom_range(0, 1));
        else queue_open_path($urandom_range(1, 10));
        phase_items += outline_q.size();
        send_outline();
      end
      random_items += phase_items;
    end

    settle();
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/ccaw_pkg.sv
src/ccaw_update.sv
src/chain_code_area_winding.sv
sim/chain_code_area_winding_checker.sv
sim/chain_code_area_winding_tb.sv
